@@ rtl/core/brb_pkg.sv @@
// Shared widths, constants, command codes and control structs of the byte ring buffer.
package brb_pkg;

   localparam int DATA_W   = 8;
   localparam int PTR_W    = 12;
   localparam int LEN_W    = 12;
   localparam int SUM_W    = PTR_W + 1;
   localparam int SLOTS    = 1 << PTR_W;
   localparam int CAPACITY = SLOTS - 1;
   localparam int MAX_RUN  = 64;
   localparam int RUN_W    = $clog2(MAX_RUN + 1);

   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_ADV_WR  = 3'd3,
      CMD_ADV_RD  = 3'd4,
      CMD_CLEAR   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_ROOM   = 2'd1,
      ST_RUN_LIMIT = 2'd2
   } status_type;

   typedef struct packed {
      logic take;
      logic step;
      logic load;
   } ctl_type;

   typedef struct packed {
      logic run_go;
      logic more_bytes;
   } dps_type;

endpackage

@@ rtl/core/brb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/brb_ctrl.sv @@
// Controller state machine sequencing transfers, byte reads and result loads.
module brb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  brb_pkg::dps_type dp_status,
   output brb_pkg::ctl_type dp_ctl
);

   typedef enum logic [1:0] {
      IDLE,
      READ,
      EMIT,
      HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      valid_ff;
   logic      take;

   assign take = req_tvalid & ready_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (take) begin
               state_in = dp_status.run_go ? READ : EMIT;
            end
         end
         READ: state_in = EMIT;
         EMIT: state_in = HOLD;
         HOLD: begin
            if (rsp_tready) begin
               state_in = dp_status.more_bytes ? READ : IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
         valid_ff <= (state_in == HOLD);
      end
   end

   assign dp_ctl.take = take;
   assign dp_ctl.step = (state_ff == READ);
   assign dp_ctl.load = (state_ff == EMIT);
   assign req_tready  = ready_ff;
   assign rsp_tvalid  = valid_ff;

endmodule

@@ rtl/core/brb_datapath.sv @@
// Datapath: pointers, byte store, fill arithmetic and result register.
module brb_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  brb_pkg::ctl_type              dp_ctl,
   output brb_pkg::dps_type              dp_status,
   input  logic [2:0]                    req_command,
   input  logic [brb_pkg::DATA_W-1:0]    req_data_in,
   input  logic [brb_pkg::LEN_W-1:0]     req_length,
   input  logic                          req_first,
   output logic [brb_pkg::DATA_W-1:0]    rsp_data_out,
   output brb_pkg::status_type           rsp_status,
   output logic [brb_pkg::PTR_W-1:0]     rsp_used,
   output logic [brb_pkg::PTR_W-1:0]     rsp_free,
   output logic [brb_pkg::PTR_W-1:0]     rsp_direct_wr,
   output logic [brb_pkg::PTR_W-1:0]     rsp_direct_rd,
   output logic                          rsp_last
);

   localparam logic [brb_pkg::SUM_W-1:0] SLOTS_V = brb_pkg::SUM_W'(brb_pkg::SLOTS);
   localparam logic [brb_pkg::SUM_W-1:0] CAP_V   = brb_pkg::SUM_W'(brb_pkg::CAPACITY);
   localparam logic [brb_pkg::LEN_W-1:0] RUN_V   = brb_pkg::LEN_W'(brb_pkg::MAX_RUN);
   localparam logic [brb_pkg::SUM_W-1:0] ONE_S   = brb_pkg::SUM_W'(1);
   localparam logic [brb_pkg::PTR_W-1:0] ONE_P   = brb_pkg::PTR_W'(1);
   localparam logic [brb_pkg::RUN_W-1:0] ONE_R   = brb_pkg::RUN_W'(1);

   logic [brb_pkg::PTR_W-1:0]  wp_ff, wp_in;
   logic [brb_pkg::PTR_W-1:0]  rp_ff, rp_in;
   logic                       acc_ff, acc_in;
   logic                       run_ff, run_in;
   logic                       pop_ff, pop_in;
   logic [brb_pkg::PTR_W-1:0]  pos_ff, pos_in;
   logic [brb_pkg::RUN_W-1:0]  cnt_ff, cnt_in;
   brb_pkg::status_type        st_ff, st_in;

   logic [brb_pkg::DATA_W-1:0] data_ff;
   brb_pkg::status_type        ostat_ff;
   logic [brb_pkg::PTR_W-1:0]  used_ff, free_ff, dwr_ff, drd_ff;
   logic                       last_ff;

   logic [brb_pkg::PTR_W-1:0]  used_w, free_w, dwr_w, drd_w;
   logic [brb_pkg::SUM_W-1:0]  dwr_x, drd_x;
   logic                       wrap_n;
   logic                       push_ok;
   logic                       acc_new;
   logic                       run_go;
   logic [brb_pkg::DATA_W-1:0] ram_rdata;
   brb_pkg::cmd_type           cmd;

   assign cmd    = brb_pkg::cmd_type'(req_command);
   assign wrap_n = (wp_ff >= rp_ff);
   assign used_w = wp_ff - rp_ff;
   assign free_w = brb_pkg::PTR_W'(CAP_V) - used_w;

   always_comb begin
      if (wrap_n) begin
         dwr_x = (rp_ff == '0) ? CAP_V - {1'b0, wp_ff} : SLOTS_V - {1'b0, wp_ff};
         drd_x = {1'b0, used_w};
      end else begin
         dwr_x = {1'b0, rp_ff} - {1'b0, wp_ff} - ONE_S;
         drd_x = SLOTS_V - {1'b0, rp_ff};
      end
   end

   assign dwr_w = dwr_x[brb_pkg::PTR_W-1:0];
   assign drd_w = drd_x[brb_pkg::PTR_W-1:0];

   assign acc_new = req_first ? (req_length <= free_w) : acc_ff;
   assign push_ok = acc_new && (free_w != '0);
   assign run_go  = ((cmd == brb_pkg::CMD_POP) || (cmd == brb_pkg::CMD_PEEK))
                    && (req_length <= used_w) && (req_length <= RUN_V)
                    && (req_length != '0);

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      acc_in = acc_ff;
      run_in = run_ff;
      pop_in = pop_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      st_in  = st_ff;
      if (dp_ctl.take) begin
         run_in = 1'b0;
         st_in  = brb_pkg::ST_OK;
         case (cmd)
            brb_pkg::CMD_PUSH: begin
               acc_in = acc_new;
               if (push_ok) begin
                  wp_in = wp_ff + ONE_P;
               end else begin
                  st_in = brb_pkg::ST_NO_ROOM;
               end
            end
            brb_pkg::CMD_POP, brb_pkg::CMD_PEEK: begin
               if (req_length > used_w) begin
                  st_in = brb_pkg::ST_NO_ROOM;
               end else if (req_length > RUN_V) begin
                  st_in = brb_pkg::ST_RUN_LIMIT;
               end else if (run_go) begin
                  run_in = 1'b1;
                  pop_in = (cmd == brb_pkg::CMD_POP);
                  pos_in = rp_ff;
                  cnt_in = req_length[brb_pkg::RUN_W-1:0];
               end
            end
            brb_pkg::CMD_ADV_WR: wp_in = wp_ff + req_length;
            brb_pkg::CMD_ADV_RD: rp_in = rp_ff + req_length;
            brb_pkg::CMD_CLEAR: begin
               wp_in = '0;
               rp_in = '0;
            end
            default: ;
         endcase
      end else if (dp_ctl.step) begin
         pos_in = pos_ff + ONE_P;
         cnt_in = cnt_ff - ONE_R;
         if (pop_ff) begin
            rp_in = pos_ff + ONE_P;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         acc_ff <= 1'b0;
         run_ff <= 1'b0;
         pop_ff <= 1'b0;
         cnt_ff <= '0;
         st_ff  <= brb_pkg::ST_OK;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         acc_ff <= acc_in;
         run_ff <= run_in;
         pop_ff <= pop_in;
         cnt_ff <= cnt_in;
         st_ff  <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (dp_ctl.load) begin
         data_ff  <= run_ff ? ram_rdata : '0;
         ostat_ff <= st_ff;
         used_ff  <= used_w;
         free_ff  <= free_w;
         dwr_ff   <= dwr_w;
         drd_ff   <= drd_w;
         last_ff  <= !run_ff || (cnt_ff == '0);
      end
   end

   brb_ram #(
      .WIDTH (brb_pkg::DATA_W),
      .DEPTH (brb_pkg::SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (dp_ctl.take && (cmd == brb_pkg::CMD_PUSH) && push_ok),
      .wr_addr (wp_ff),
      .wr_data (req_data_in),
      .rd_en   (dp_ctl.step),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign dp_status.run_go     = run_go;
   assign dp_status.more_bytes = run_ff && (cnt_ff != '0);

   assign rsp_data_out  = data_ff;
   assign rsp_status    = ostat_ff;
   assign rsp_used      = used_ff;
   assign rsp_free      = free_ff;
   assign rsp_direct_wr = dwr_ff;
   assign rsp_direct_rd = drd_ff;
   assign rsp_last      = last_ff;

endmodule

@@ rtl/core/byte_ring_buffer.sv @@
// Byte ring buffer top level: stream ports around the controller and datapath.
// Single-result commands: the request is taken in IDLE, the result is loaded in EMIT and offered in HOLD.
// Pop/peek runs: each byte goes through READ (the store's registered read), EMIT and HOLD; output stall extends HOLD.
// One item in flight; the next request is taken the cycle after the last result transfer.
// Reset clears both pointers and the message flag; store contents stay undefined, no clear pass.
module byte_ring_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_in[7:0], length[19:8], zero fill[23:20]
   input  logic [3:0]  req_tuser,  // command[2:0], first_of_message[3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // data_out, used_count, free_count, direct_write_len,
                                   // direct_read_len (12 bits each after data_out)
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast
);

   brb_pkg::ctl_type              dp_ctl;
   brb_pkg::dps_type              dp_status;
   brb_pkg::status_type           status;
   logic [brb_pkg::DATA_W-1:0]    data_out;
   logic [brb_pkg::PTR_W-1:0]     used_count, free_count, direct_wr, direct_rd;

   brb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_ctl     (dp_ctl)
   );

   brb_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp_ctl        (dp_ctl),
      .dp_status     (dp_status),
      .req_command   (req_tuser[2:0]),
      .req_data_in   (req_tdata[7:0]),
      .req_length    (req_tdata[19:8]),
      .req_first     (req_tuser[3]),
      .rsp_data_out  (data_out),
      .rsp_status    (status),
      .rsp_used      (used_count),
      .rsp_free      (free_count),
      .rsp_direct_wr (direct_wr),
      .rsp_direct_rd (direct_rd),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {direct_rd, direct_wr, free_count, used_count, data_out};
   assign rsp_tuser = status;

endmodule

@@ dv/tb_byte_ring_buffer.sv @@
// Testbench for byte_ring_buffer: directed and random command streams checked against a predictor.
`timescale 1ns / 1ps
module tb_byte_ring_buffer;

   localparam logic [2:0] CMD_RSVD6   = 3'd6;
   localparam logic [2:0] CMD_RSVD7   = 3'd7;
   localparam int         DRAIN_WAIT  = 20;

   typedef struct {
      logic [7:0]           data;
      brb_pkg::status_type  status;
      logic [11:0]          used;
      logic [11:0]          free;
      logic [11:0]          wr_span;
      logic [11:0]          rd_span;
      logic                 last;
   } ring_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // data_in[7:0], length[19:8], zero fill[23:20]
   logic [3:0]  req_tuser = '0;  // command[2:0], first_of_message[3]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;       // data_out[7:0], used[19:8], free[31:20],
                                 // direct_write_len[43:32], direct_read_len[55:44]
   logic [1:0]  rsp_tuser;       // status[1:0]
   logic        rsp_tlast;

   // ring shadow
   int          rd_ptr = 0;
   int          wr_ptr = 0;
   bit          msg_ok = 1'b0;
   logic [7:0]  shadow_store [brb_pkg::SLOTS];
   bit          shadow_written [brb_pkg::SLOTS];

   ring_result_type pending_results [$];
   ring_result_type want_result;

   int send_idle_pct  = 14;
   int recv_idle_pct  = 52;
   int hold_left      = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int longest_run    = 0;
   int limit_hits     = 0;

   byte_ring_buffer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int stored_count();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : brb_pkg::SLOTS + wr_ptr - rd_ptr;
   endfunction

   function automatic int room_count();
      return brb_pkg::CAPACITY - stored_count();
   endfunction

   function automatic int write_span();
      if (wr_ptr >= rd_ptr) begin
         return (rd_ptr == 0) ? brb_pkg::CAPACITY - wr_ptr : brb_pkg::CAPACITY - wr_ptr + 1;
      end
      return rd_ptr - wr_ptr - 1;
   endfunction

   function automatic int read_span();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : brb_pkg::SLOTS - rd_ptr;
   endfunction

   function automatic void note_result(logic [7:0] data, brb_pkg::status_type st, bit last);
      ring_result_type r;
      r.data    = data;
      r.status  = st;
      r.used    = 12'(stored_count());
      r.free    = 12'(room_count());
      r.wr_span = 12'(write_span());
      r.rd_span = 12'(read_span());
      r.last    = last;
      pending_results.push_back(r);
   endfunction

   // True when a pop or peek of len bytes would read store entries never written.
   function automatic bit run_hits_unwritten(int len);
      int i;
      if (len == 0 || len > stored_count() || len > brb_pkg::MAX_RUN) return 1'b0;
      for (i = 0; i < len; i++) begin
         if (!shadow_written[12'((rd_ptr + i) % brb_pkg::SLOTS)]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void apply_command(logic [2:0] cmd, logic [7:0] din, int len, bit first);
      int pos;
      int i;
      case (cmd)
         brb_pkg::CMD_PUSH: begin
            if (first) msg_ok = (len <= room_count());
            if (msg_ok && room_count() > 0) begin
               shadow_store[12'(wr_ptr)]   = din;
               shadow_written[12'(wr_ptr)] = 1'b1;
               wr_ptr = (wr_ptr + 1) % brb_pkg::SLOTS;
               note_result(8'd0, brb_pkg::ST_OK, 1'b1);
            end else begin
               note_result(8'd0, brb_pkg::ST_NO_ROOM, 1'b1);
            end
         end
         brb_pkg::CMD_POP, brb_pkg::CMD_PEEK: begin
            if (len > stored_count()) begin
               note_result(8'd0, brb_pkg::ST_NO_ROOM, 1'b1);
            end else if (len > brb_pkg::MAX_RUN) begin
               note_result(8'd0, brb_pkg::ST_RUN_LIMIT, 1'b1);
               limit_hits++;
            end else if (len == 0) begin
               note_result(8'd0, brb_pkg::ST_OK, 1'b1);
            end else begin
               pos = rd_ptr;
               if (len > longest_run) longest_run = len;
               for (i = 0; i < len; i++) begin
                  logic [7:0] b;
                  b   = shadow_store[12'(pos)];
                  pos = (pos + 1) % brb_pkg::SLOTS;
                  if (cmd == brb_pkg::CMD_POP) rd_ptr = pos;
                  note_result(b, brb_pkg::ST_OK, i == len - 1);
               end
            end
         end
         brb_pkg::CMD_ADV_WR: begin
            wr_ptr = (wr_ptr + len) % brb_pkg::SLOTS;
            note_result(8'd0, brb_pkg::ST_OK, 1'b1);
         end
         brb_pkg::CMD_ADV_RD: begin
            rd_ptr = (rd_ptr + len) % brb_pkg::SLOTS;
            note_result(8'd0, brb_pkg::ST_OK, 1'b1);
         end
         brb_pkg::CMD_CLEAR: begin
            rd_ptr = 0;
            wr_ptr = 0;
            note_result(8'd0, brb_pkg::ST_OK, 1'b1);
         end
         default: note_result(8'd0, brb_pkg::ST_OK, 1'b1);
      endcase
   endfunction

   task automatic send_item(logic [2:0] cmd, logic [7:0] din, int len, bit first);
      int n;
      n = len;
      if ((cmd == brb_pkg::CMD_POP || cmd == brb_pkg::CMD_PEEK) && run_hits_unwritten(len))
         n = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, n[11:0], din};
      req_tuser  <= {first, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_command(cmd, din, n, first);
      items_sent++;
   endtask

   task automatic send_message(int len);
      int i;
      for (i = 0; i < len; i++) begin
         send_item(brb_pkg::CMD_PUSH, 8'($urandom_range(255)),
                   (i == 0) ? len : $urandom_range(4095), i == 0);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            $error("result transfer with nothing expected: tdata %h", rsp_tdata);
         end else begin
            want_result = pending_results.pop_front();
            compare_field("data_out", 16'(want_result.data), 16'(rsp_tdata[7:0]));
            compare_field("status", 16'(want_result.status), 16'(rsp_tuser));
            compare_field("used_count", 16'(want_result.used), 16'(rsp_tdata[19:8]));
            compare_field("free_count", 16'(want_result.free), 16'(rsp_tdata[31:20]));
            compare_field("direct_write_len", 16'(want_result.wr_span),
                          16'(rsp_tdata[43:32]));
            compare_field("direct_read_len", 16'(want_result.rd_span),
                          16'(rsp_tdata[55:44]));
            compare_field("last", 16'(want_result.last), 16'(rsp_tlast));
         end
      end
   end

   task automatic test_empty_and_unknown();
      send_item(brb_pkg::CMD_POP, 8'h00, 1, 1'b0);
      send_item(brb_pkg::CMD_PEEK, 8'h00, 0, 1'b0);
      send_item(brb_pkg::CMD_PUSH, 8'h3C, 5, 1'b0);
      send_item(CMD_RSVD6, 8'hFF, 4095, 1'b1);
      send_item(CMD_RSVD7, 8'h5A, 2730, 1'b0);
   endtask

   task automatic test_message_push_pop();
      send_item(brb_pkg::CMD_PUSH, 8'h00, 3, 1'b1);
      send_item(brb_pkg::CMD_PUSH, 8'hFF, 4095, 1'b0);
      send_item(brb_pkg::CMD_PUSH, 8'hA5, 0, 1'b0);
      send_item(brb_pkg::CMD_PUSH, 8'h11, 4095, 1'b1);
      send_item(brb_pkg::CMD_PUSH, 8'h22, 1, 1'b0);
      send_item(brb_pkg::CMD_PEEK, 8'h00, 3, 1'b0);
      send_item(brb_pkg::CMD_POP, 8'h00, 2, 1'b0);
      send_item(brb_pkg::CMD_POP, 8'h00, 4095, 1'b0);
      send_item(brb_pkg::CMD_POP, 8'h00, 1, 1'b0);
   endtask

   task automatic test_full_and_wrap();
      send_item(brb_pkg::CMD_CLEAR, 8'h00, 0, 1'b0);
      send_item(brb_pkg::CMD_ADV_WR, 8'h00, brb_pkg::CAPACITY, 1'b0);
      send_item(brb_pkg::CMD_PUSH, 8'h77, 0, 1'b1);
      send_item(brb_pkg::CMD_ADV_RD, 8'h00, brb_pkg::CAPACITY, 1'b0);
      send_item(brb_pkg::CMD_PUSH, 8'h81, 4, 1'b1);
      send_item(brb_pkg::CMD_PUSH, 8'h42, 0, 1'b0);
      send_item(brb_pkg::CMD_PUSH, 8'hC3, 0, 1'b0);
      send_item(brb_pkg::CMD_PUSH, 8'h18, 0, 1'b0);
      send_item(brb_pkg::CMD_PEEK, 8'h00, 4, 1'b0);
      send_item(brb_pkg::CMD_POP, 8'h00, 4, 1'b0);
   endtask

   task automatic test_run_limits();
      send_item(brb_pkg::CMD_CLEAR, 8'h00, 0, 1'b0);
      send_item(brb_pkg::CMD_ADV_WR, 8'h00, 100, 1'b0);
      send_item(brb_pkg::CMD_POP, 8'h00, brb_pkg::MAX_RUN + 1, 1'b0);
      send_item(brb_pkg::CMD_PEEK, 8'h00, 101, 1'b0);
      send_item(brb_pkg::CMD_CLEAR, 8'h00, 0, 1'b0);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_left = 150;
      send_message(brb_pkg::MAX_RUN + 6);
      send_item(brb_pkg::CMD_PEEK, 8'h00, brb_pkg::MAX_RUN, 1'b0);
      send_item(brb_pkg::CMD_POP, 8'h00, brb_pkg::MAX_RUN, 1'b0);
      send_item(brb_pkg::CMD_POP, 8'h00, 7, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_traffic(int count);
      int start;
      int pick;
      int lim;
      int len;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(99);
         lim  = (stored_count() < brb_pkg::MAX_RUN) ? stored_count() : brb_pkg::MAX_RUN;
         if ($urandom_range(9) < 8 && lim > 0) begin
            len = $urandom_range(lim, 1);
         end else if ($urandom_range(1)) begin
            len = $urandom_range(brb_pkg::MAX_RUN + 1, 200);
         end else begin
            len = $urandom_range(4095);
         end
         if (pick < 50) begin
            send_message($urandom_range(24, 1));
         end else if (pick < 70) begin
            send_item(brb_pkg::CMD_POP, 8'($urandom_range(255)), len, 1'($urandom_range(1)));
         end else if (pick < 80) begin
            send_item(brb_pkg::CMD_PEEK, 8'($urandom_range(255)), len, 1'($urandom_range(1)));
         end else if (pick < 85) begin
            send_item(brb_pkg::CMD_ADV_RD, 8'($urandom_range(255)), $urandom_range(8),
                      1'($urandom_range(1)));
         end else if (pick < 88) begin
            send_item(brb_pkg::CMD_ADV_WR, 8'($urandom_range(255)),
                      ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(16),
                      1'($urandom_range(1)));
         end else if (pick < 91) begin
            send_item(brb_pkg::CMD_CLEAR, 8'($urandom_range(255)), $urandom_range(4095),
                      1'($urandom_range(1)));
         end else if (pick < 95) begin
            send_item(brb_pkg::CMD_PUSH, 8'($urandom_range(255)), $urandom_range(4095), 1'b1);
            send_item(brb_pkg::CMD_PUSH, 8'($urandom_range(255)), $urandom_range(4095), 1'b0);
         end else if (pick < 97) begin
            send_item(brb_pkg::CMD_PUSH, 8'($urandom_range(255)), $urandom_range(4095), 1'b0);
         end else begin
            send_item($urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7, 8'($urandom_range(255)),
                      $urandom_range(4095), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_unknown();
      test_message_push_pop();
      test_full_and_wrap();
      test_run_limits();
      send_idle_pct = 0;
      test_backpressure();
      send_idle_pct = 14;
      recv_idle_pct = 52;
      test_random_traffic(35);
      send_idle_pct = 52;
      recv_idle_pct = 14;
      test_random_traffic(35);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(30);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d command transfers and checked %0d result transfers.",
               items_sent, results_seen);
      $display("Longest pop/peek run %0d bytes; %0d runs rejected over the run limit.",
               longest_run, limit_hits);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/brb_pkg.sv
rtl/core/brb_ram.sv
rtl/core/brb_ctrl.sv
rtl/core/brb_datapath.sv
rtl/core/byte_ring_buffer.sv
dv/tb_byte_ring_buffer.sv
